/* src/tcfs_pkg.sv */
// Shared constants, codes and types of the text column field selector.
package tcfs_pkg;

    localparam int DEF_RANGE_SLOTS       = 4;
    localparam int DEF_FIRST_FIELD_DEPTH = 63;
    localparam int DEF_POSITION_BITS     = 16;

    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int RANGE_HALF_W = 16;
    localparam int RANGE_CNT_W  = 3;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] TAB_BYTE     = 8'd9;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_MODE   = 4'd0,
        CFG_DELIMITER    = 4'd1,
        CFG_SUPPRESS     = 4'd2,
        CFG_RANGE_COUNT  = 4'd3,
        CFG_RANGE_WORD_0 = 4'd4,
        CFG_RANGE_WORD_1 = 4'd5,
        CFG_RANGE_WORD_2 = 4'd6,
        CFG_RANGE_WORD_3 = 4'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLAN,
        ST_DUMP_RD,
        ST_DUMP_WR,
        ST_TAIL
    } t_state;

    // What an accepted transaction asks of the sequencer.
    typedef enum logic [2:0] {
        K_EOS,
        K_NL,
        K_BYTE,
        K_STORE,
        K_FIRST_DELIM,
        K_FIELD_DELIM,
        K_FIELD_DATA
    } t_kind;

    typedef struct packed {
        logic                   field_mode;
        logic [7:0]             delimiter;
        logic                   suppress;
        logic [RANGE_CNT_W-1:0] range_count;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       buffer_overflowed;
    } t_out_item;

endpackage

/* src/tcfs_ifs.sv */
// Channel interfaces: input bytes, result bytes and configuration writes.
interface tcfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;
    modport source (output valid, data_byte, end_of_stream, input ready);
    modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

interface tcfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       buffer_overflowed;
    modport source (output valid, out_byte, last_of_run, buffer_overflowed, input ready);
    modport sink   (input valid, out_byte, last_of_run, buffer_overflowed, output ready);
endinterface

interface tcfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  addr;
    logic [31:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

/* src/tcfs_range_unit.sv */
// Shared range comparator: tests one position against one packed range word.
module tcfs_range_unit #(
    parameter int POSITION_BITS = tcfs_pkg::DEF_POSITION_BITS
) (
    input  logic [POSITION_BITS-1:0]          i_pos,
    input  logic [2*tcfs_pkg::RANGE_HALF_W-1:0] i_word,
    input  logic                              i_en,
    output logic                              o_hit
);
    import tcfs_pkg::*;

    logic [RANGE_HALF_W-1:0] w_lo;
    logic [RANGE_HALF_W-1:0] w_hi;
    logic [RANGE_HALF_W-1:0] w_pos;

    assign w_lo  = i_word[RANGE_HALF_W-1:0];
    assign w_hi  = i_word[2*RANGE_HALF_W-1:RANGE_HALF_W];
    assign w_pos = RANGE_HALF_W'(i_pos);

    // An upper bound of zero is open ended.
    assign o_hit = i_en && (w_pos >= w_lo) && ((w_hi == '0) || (w_pos <= w_hi));

endmodule

/* src/tcfs_ff_buf.sv */
// First-field byte store: one write port, one registered read port.
module tcfs_ff_buf #(
    parameter int DEPTH = tcfs_pkg::DEF_FIRST_FIELD_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/tcfs_core.sv */
// Sequencer, line state and output register of the column selector.
module tcfs_core #(
    parameter int RANGE_SLOTS       = tcfs_pkg::DEF_RANGE_SLOTS,
    parameter int FIRST_FIELD_DEPTH = tcfs_pkg::DEF_FIRST_FIELD_DEPTH,
    parameter int POSITION_BITS     = tcfs_pkg::DEF_POSITION_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [7:0]                              i_data_byte,
    input  logic                                    i_end_of_stream,
    input  tcfs_pkg::t_cfg                          i_cfg,
    input  logic [RANGE_SLOTS-1:0][2*tcfs_pkg::RANGE_HALF_W-1:0] i_range,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output tcfs_pkg::t_out_item                     o_out
);
    import tcfs_pkg::*;

    localparam int SW    = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int AW    = (FIRST_FIELD_DEPTH > 1) ? $clog2(FIRST_FIELD_DEPTH) : 1;
    localparam int LEN_W = $clog2(FIRST_FIELD_DEPTH + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [RANGE_CNT_W-1:0] SLOT_LIMIT = RANGE_CNT_W'(RANGE_SLOTS);

    t_state                 r_state, n_state;
    t_kind                  r_kind, n_kind;
    logic [7:0]             r_byte, n_byte;
    logic                   r_line_end, n_line_end;
    logic                   r_second, n_second;
    logic [SW-1:0]          r_slot, n_slot;
    logic                   r_hit, n_hit;
    logic                   r_hit_a, n_hit_a;
    logic                   r_tail_valid, n_tail_valid;
    logic [7:0]             r_tail_byte, n_tail_byte;
    logic [AW-1:0]          r_idx, n_idx;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                   r_ds, n_ds;
    logic                   r_fp, n_fp;
    logic [LEN_W-1:0]       r_len, n_len;
    logic                   r_ovf, n_ovf;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    t_kind                  w_kind;
    logic                   w_out_free;
    logic                   w_undelim_dump;
    logic                   w_nl_emit;
    logic                   w_len_nz;
    logic                   w_slot_last;
    logic                   w_unit_en;
    logic                   w_unit_hit;
    logic                   w_dump_last;
    logic                   w_plan_dump;
    logic                   w_plan_tail;
    logic [RANGE_CNT_W-1:0] w_cnt_eff;
    logic [POSITION_BITS-1:0] w_pos_inc;
    logic                   w_wr_en;
    logic [7:0]             w_rd_data;

    // Decode the incoming transaction.
    always_comb begin
        if (i_end_of_stream) begin
            w_kind = K_EOS;
        end else if (i_data_byte == NEWLINE_BYTE) begin
            w_kind = K_NL;
        end else if (!i_cfg.field_mode) begin
            w_kind = K_BYTE;
        end else if (!r_ds) begin
            w_kind = (i_data_byte == i_cfg.delimiter) ? K_FIRST_DELIM : K_STORE;
        end else begin
            w_kind = (i_data_byte == i_cfg.delimiter) ? K_FIELD_DELIM : K_FIELD_DATA;
        end
    end

    assign w_out_free     = !r_out_valid || i_out_ready;
    assign w_undelim_dump = i_cfg.field_mode && !r_ds && !i_cfg.suppress;
    assign w_nl_emit      = !i_cfg.field_mode || r_ds || !i_cfg.suppress;
    assign w_len_nz       = (r_len != '0);
    assign w_slot_last    = (r_slot == SW'(RANGE_SLOTS - 1));
    assign w_cnt_eff      = (i_cfg.range_count > SLOT_LIMIT) ? SLOT_LIMIT : i_cfg.range_count;
    assign w_unit_en      = (RANGE_CNT_W'(r_slot) < w_cnt_eff);
    assign w_pos_inc      = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign w_dump_last    = (LEN_W'(r_idx) == r_len - LEN_W'(1));
    assign w_plan_dump    = (r_kind == K_FIRST_DELIM) && r_second && r_hit_a && w_len_nz;

    always_comb begin
        case (r_kind)
            K_FIRST_DELIM: w_plan_tail = r_hit_a && r_hit;
            K_FIELD_DELIM: w_plan_tail = r_hit && r_fp;
            K_BYTE:        w_plan_tail = r_hit;
            K_FIELD_DATA:  w_plan_tail = r_hit;
            default:       w_plan_tail = 1'b0;
        endcase
    end

    tcfs_range_unit #(
        .POSITION_BITS (POSITION_BITS)
    ) u_range_unit (
        .i_pos  (r_pos),
        .i_word (i_range[r_slot]),
        .i_en   (w_unit_en),
        .o_hit  (w_unit_hit)
    );

    assign w_wr_en = (r_state == ST_IDLE) && i_in_valid && (w_kind == K_STORE)
                     && (r_len < LEN_W'(FIRST_FIELD_DEPTH));

    tcfs_ff_buf #(
        .DEPTH (FIRST_FIELD_DEPTH)
    ) u_ff_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_len[AW-1:0]),
        .i_wr_data (i_data_byte),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (w_kind)
                        K_EOS: begin
                            n_state = (w_undelim_dump && w_len_nz) ? ST_DUMP_RD : ST_IDLE;
                        end
                        K_NL: begin
                            if (!w_nl_emit) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_state = (w_undelim_dump && w_len_nz) ? ST_DUMP_RD : ST_TAIL;
                            end
                        end
                        K_STORE: n_state = ST_IDLE;
                        default: n_state = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_slot_last) begin
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                if ((r_kind == K_FIRST_DELIM) && !r_second) begin
                    n_state = ST_SCAN;
                end else if (w_plan_dump) begin
                    n_state = ST_DUMP_RD;
                end else if (w_plan_tail) begin
                    n_state = ST_TAIL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DUMP_RD: n_state = ST_DUMP_WR;
            ST_DUMP_WR: begin
                if (w_out_free) begin
                    if (!w_dump_last) begin
                        n_state = ST_DUMP_RD;
                    end else begin
                        n_state = r_tail_valid ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and line state.
    always_comb begin
        logic      v_push;
        logic      v_line_reset;
        t_out_item v_item;

        v_push       = 1'b0;
        v_line_reset = 1'b0;
        v_item       = '0;

        n_kind       = r_kind;
        n_byte       = r_byte;
        n_line_end   = r_line_end;
        n_second     = r_second;
        n_slot       = r_slot;
        n_hit        = r_hit;
        n_hit_a      = r_hit_a;
        n_tail_valid = r_tail_valid;
        n_tail_byte  = r_tail_byte;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_ds         = r_ds;
        n_fp         = r_fp;
        n_len        = r_len;
        n_ovf        = r_ovf;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_kind       = w_kind;
                    n_byte       = i_data_byte;
                    n_slot       = '0;
                    n_hit        = 1'b0;
                    n_second     = 1'b0;
                    n_idx        = '0;
                    n_line_end   = 1'b0;
                    n_tail_valid = 1'b0;
                    case (w_kind)
                        K_EOS: begin
                            n_line_end = 1'b1;
                            if (!(w_undelim_dump && w_len_nz)) begin
                                v_line_reset = 1'b1;
                            end
                        end
                        K_NL: begin
                            n_line_end   = 1'b1;
                            n_tail_valid = 1'b1;
                            n_tail_byte  = NEWLINE_BYTE;
                            if (!w_nl_emit) begin
                                v_line_reset = 1'b1;
                            end
                        end
                        K_STORE: begin
                            if (r_len < LEN_W'(FIRST_FIELD_DEPTH)) begin
                                n_len = r_len + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        K_FIELD_DELIM: n_pos = w_pos_inc;
                        K_FIRST_DELIM: n_ds  = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                n_hit  = r_hit | w_unit_hit;
                n_slot = w_slot_last ? '0 : r_slot + 1'b1;
            end
            ST_PLAN: begin
                case (r_kind)
                    K_FIRST_DELIM: begin
                        if (!r_second) begin
                            // Field one decided; advance and test field two.
                            n_hit_a  = r_hit;
                            n_pos    = w_pos_inc;
                            n_second = 1'b1;
                            n_slot   = '0;
                            n_hit    = 1'b0;
                        end else begin
                            n_tail_valid = w_plan_tail;
                            n_tail_byte  = i_cfg.delimiter;
                            n_fp         = r_hit_a || r_hit;
                        end
                    end
                    K_FIELD_DELIM: begin
                        n_tail_valid = w_plan_tail;
                        n_tail_byte  = i_cfg.delimiter;
                        n_fp         = r_fp || r_hit;
                    end
                    K_BYTE: begin
                        n_tail_valid = w_plan_tail;
                        n_tail_byte  = r_byte;
                        n_pos        = w_pos_inc;
                    end
                    K_FIELD_DATA: begin
                        n_tail_valid = w_plan_tail;
                        n_tail_byte  = r_byte;
                    end
                    default: ;
                endcase
            end
            ST_DUMP_WR: begin
                if (w_out_free) begin
                    v_push                   = 1'b1;
                    v_item.out_byte          = w_rd_data;
                    v_item.last_of_run       = w_dump_last && !r_tail_valid;
                    v_item.buffer_overflowed = r_ovf;
                    if (!w_dump_last) begin
                        n_idx = r_idx + 1'b1;
                    end else if (!r_tail_valid && r_line_end) begin
                        v_line_reset = 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                if (w_out_free) begin
                    v_push                   = 1'b1;
                    v_item.out_byte          = r_tail_byte;
                    v_item.last_of_run       = 1'b1;
                    v_item.buffer_overflowed = r_ovf;
                    if (r_line_end) begin
                        v_line_reset = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (v_line_reset) begin
            n_pos = POSITION_BITS'(1);
            n_ds  = 1'b0;
            n_fp  = 1'b0;
            n_len = '0;
            n_ovf = 1'b0;
        end

        n_out = r_out;
        if (v_push) begin
            n_out_valid = 1'b1;
            n_out       = v_item;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= POSITION_BITS'(1);
            r_ds        <= 1'b0;
            r_fp        <= 1'b0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_ds        <= n_ds;
            r_fp        <= n_fp;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_byte       <= n_byte;
        r_line_end   <= n_line_end;
        r_second     <= n_second;
        r_slot       <= n_slot;
        r_hit        <= n_hit;
        r_hit_a      <= n_hit_a;
        r_tail_valid <= n_tail_valid;
        r_tail_byte  <= n_tail_byte;
        r_idx        <= n_idx;
        r_out        <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* src/text_column_field_selector_top.sv */
// Top level of the text column field selector: configuration registers and channels.
//
// Column selector in the manner of cut: bytes arrive one per transaction, a newline
// ends the line, and the block passes on either the selected byte positions (byte
// mode) or the selected delimiter-separated fields joined by the delimiter (field
// mode), using up to RANGE_SLOTS inclusive ranges where an upper bound of zero runs to
// the end of the line. In field mode the first field waits in a FIRST_FIELD_DEPTH byte
// store until a delimiter shows up; a line without one is passed through whole, or
// dropped when suppression is set, and bytes beyond the store are dropped with
// buffer_overflowed raised for the rest of that line. Every range test goes through
// one shared comparator that sweeps the range registers one per cycle. The input takes
// a new transaction only while idle: right after a first-field byte that is only
// stored, after a sweep, a plan step and any result for a tested byte, after two sweeps
// and the plan steps and any results for the first delimiter, and after a store read
// and a result per stored byte while the first-field store is drained. Results leave
// through an output register, so the next transaction is taken while the last result
// still waits. last_of_run marks the final result of each input transaction.
// Configuration writes are accepted every cycle and must only happen while idle.
module text_column_field_selector_top #(
    parameter int RANGE_SLOTS       = tcfs_pkg::DEF_RANGE_SLOTS,
    parameter int FIRST_FIELD_DEPTH = tcfs_pkg::DEF_FIRST_FIELD_DEPTH,
    parameter int POSITION_BITS     = tcfs_pkg::DEF_POSITION_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tcfs_in_if.sink           i_in_ch,
    tcfs_out_if.source        o_out_ch,
    tcfs_cfg_if.sink          i_cfg_ch
);
    import tcfs_pkg::*;

    // Configuration registers.
    logic                   r_field_mode;
    logic [7:0]             r_delimiter;
    logic                   r_suppress;
    logic [RANGE_CNT_W-1:0] r_range_count;
    logic [RANGE_SLOTS-1:0][2*RANGE_HALF_W-1:0] r_range;

    logic      w_cfg_we;
    t_cfg      w_cfg;
    t_out_item w_out;

    // Writes are always taken; slots past RANGE_SLOTS are never used, so drop them.
    assign i_cfg_ch.ready = 1'b1;
    assign w_cfg_we       = i_cfg_ch.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_mode  <= 1'b0;
            r_delimiter   <= TAB_BYTE;
            r_suppress    <= 1'b0;
            r_range_count <= '0;
            r_range       <= '0;
        end else if (w_cfg_we) begin
            case (i_cfg_ch.addr)
                CFG_FIELD_MODE:  r_field_mode  <= i_cfg_ch.data[0];
                CFG_DELIMITER:   r_delimiter   <= i_cfg_ch.data[7:0];
                CFG_SUPPRESS:    r_suppress    <= i_cfg_ch.data[0];
                CFG_RANGE_COUNT: r_range_count <= i_cfg_ch.data[RANGE_CNT_W-1:0];
                default: begin
                    for (int j = 0; j < RANGE_SLOTS; j++) begin
                        if (i_cfg_ch.addr == CFG_IDX_W'(CFG_RANGE_WORD_0) + CFG_IDX_W'(j)) begin
                            r_range[j] <= i_cfg_ch.data;
                        end
                    end
                end
            endcase
        end
    end

    assign w_cfg.field_mode  = r_field_mode;
    assign w_cfg.delimiter   = r_delimiter;
    assign w_cfg.suppress    = r_suppress;
    assign w_cfg.range_count = r_range_count;

    // Sequencer with the shared range comparator and the first-field store.
    tcfs_core #(
        .RANGE_SLOTS       (RANGE_SLOTS),
        .FIRST_FIELD_DEPTH (FIRST_FIELD_DEPTH),
        .POSITION_BITS     (POSITION_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_ch.valid),
        .o_in_ready      (i_in_ch.ready),
        .i_data_byte     (i_in_ch.data_byte),
        .i_end_of_stream (i_in_ch.end_of_stream),
        .i_cfg           (w_cfg),
        .i_range         (r_range),
        .o_out_valid     (o_out_ch.valid),
        .i_out_ready     (o_out_ch.ready),
        .o_out           (w_out)
    );

    assign o_out_ch.out_byte          = w_out.out_byte;
    assign o_out_ch.last_of_run       = w_out.last_of_run;
    assign o_out_ch.buffer_overflowed = w_out.buffer_overflowed;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the text column field selector top level.
`timescale 1ns / 1ps

module testbench;
    import tcfs_pkg::*;

    // Predictor sizes follow the block's default parameters.
    localparam int SLOTS       = DEF_RANGE_SLOTS;
    localparam int STORE_DEPTH = DEF_FIRST_FIELD_DEPTH;
    localparam int POS_W       = DEF_POSITION_BITS;
    localparam int MAX_RUN     = 64;
    // Longest quiet stretch the block may spend on a transaction that yields no result.
    localparam int SETTLE_CYCLES = 4 * SLOTS + 2 * STORE_DEPTH + 40;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [POS_W-1:0] POS_LIMIT = '1;
    localparam logic [7:0] COMMA_BYTE = 8'h2C;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } text_token_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tcfs_in_if  in_ch ();
    tcfs_out_if out_ch ();
    tcfs_cfg_if cfg_ch ();

    text_column_field_selector_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus and expectation stores shared by the initial block, driver and monitor.
    text_token_t pending_tokens[$];
    t_out_item   expected_cut_bytes[$];
    t_out_item   run_bytes[$];
    int unsigned queued_tokens   = 0;
    int unsigned accepted_tokens = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;

    // Idle controls: per-side random gaps on or off, and the one-shot long hold-off.
    logic tx_idle_on    = 1'b0;
    logic rx_idle_on    = 1'b0;
    logic long_hold_req = 1'b0;
    logic hold_used;
    int unsigned hold_left;

    // Predictor copy of the configuration registers.
    logic             sel_field_mode;
    logic [7:0]       sel_delim;
    logic             sel_suppress;
    logic [2:0]       sel_range_count;
    logic [31:0]      sel_ranges[4];

    // Predictor copy of the per-line state.
    logic [POS_W-1:0] col_pos;
    logic             delim_found;
    logic             field_emitted;
    logic [7:0]       head_store[STORE_DEPTH];
    int unsigned      head_len;
    logic             head_overflow;

    // ---------------------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------------------

    // Test a byte position or field number against the active ranges.
    function automatic logic column_selected(logic [POS_W-1:0] pos);
        int unsigned used;
        logic [15:0] lo;
        logic [15:0] hi;
        used = (sel_range_count > SLOTS) ? SLOTS : sel_range_count;
        for (int i = 0; i < used; i++) begin
            lo = sel_ranges[i][15:0];
            hi = sel_ranges[i][31:16];
            if (pos >= lo && (hi == 16'd0 || pos <= hi))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Append one output byte to the run of the current transaction; drop beyond the cap.
    task automatic push_cut_byte(logic [7:0] b);
        t_out_item r;
        if (run_bytes.size() < MAX_RUN) begin
            r.out_byte          = b;
            r.last_of_run       = 1'b0;
            r.buffer_overflowed = head_overflow;
            run_bytes.push_back(r);
        end
    endtask

    task automatic dump_head_field();
        for (int i = 0; i < head_len; i++)
            push_cut_byte(head_store[i]);
    endtask

    task automatic clear_line();
        col_pos       = POS_W'(1);
        delim_found   = 1'b0;
        field_emitted = 1'b0;
        head_len      = 0;
        head_overflow = 1'b0;
    endtask

    // Advance to the next field and emit a joining delimiter if the field is printed.
    task automatic next_field();
        if (col_pos != POS_LIMIT)
            col_pos++;
        if (column_selected(col_pos)) begin
            if (field_emitted)
                push_cut_byte(sel_delim);
            field_emitted = 1'b1;
        end
    endtask

    // Work out the output bytes of one accepted input transaction.
    task automatic cut_predict(text_token_t tok);
        logic [7:0] b;
        b = tok.data_byte;
        run_bytes.delete();
        if (tok.end_of_stream) begin
            if (sel_field_mode && !delim_found && !sel_suppress)
                dump_head_field();
            clear_line();
        end else if (b == NEWLINE_BYTE) begin
            if (!sel_field_mode || delim_found) begin
                push_cut_byte(NEWLINE_BYTE);
            end else if (!sel_suppress) begin
                dump_head_field();
                push_cut_byte(NEWLINE_BYTE);
            end
            clear_line();
        end else if (!sel_field_mode) begin
            if (column_selected(col_pos))
                push_cut_byte(b);
            if (col_pos != POS_LIMIT)
                col_pos++;
        end else if (!delim_found) begin
            if (b == sel_delim) begin
                delim_found = 1'b1;
                if (column_selected(col_pos)) begin
                    dump_head_field();
                    field_emitted = 1'b1;
                end
                next_field();
            end else if (head_len < STORE_DEPTH) begin
                head_store[head_len] = b;
                head_len++;
            end else begin
                head_overflow = 1'b1;
            end
        end else if (b == sel_delim) begin
            next_field();
        end else if (column_selected(col_pos)) begin
            push_cut_byte(b);
        end
        if (run_bytes.size() > 0)
            run_bytes[run_bytes.size() - 1].last_of_run = 1'b1;
        foreach (run_bytes[i])
            expected_cut_bytes.push_back(run_bytes[i]);
    endtask

    // ---------------------------------------------------------------------------------
    // Input driver: present queued tokens, with a random gap after each transaction.
    // ---------------------------------------------------------------------------------
    text_token_t tx_token;
    int unsigned tx_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid         <= 1'b0;
            in_ch.data_byte     <= 8'd0;
            in_ch.end_of_stream <= 1'b0;
            tx_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                // Predict first so that the count never runs ahead of the expectations.
                cut_predict(tx_token);
                accepted_tokens++;
                tx_gap = tx_idle_on ? $urandom_range(0, 4) : 0;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Hold the offered token until the block takes it.
            end else if (tx_gap > 0) begin
                tx_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_tokens.size() > 0) begin
                tx_token = pending_tokens.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.data_byte     <= tx_token.data_byte;
                in_ch.end_of_stream <= tx_token.end_of_stream;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Long hold-off of the result side, counted here and triggered once on request.
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (long_hold_req && !hold_used) begin
            hold_left <= LONG_HOLD;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------------------------
    // Result monitor: check each transaction against the oldest expectation.
    // ---------------------------------------------------------------------------------
    task automatic report_mismatch(string what, t_out_item want, t_out_item got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t mismatch (%s): expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     $realtime, what, want.out_byte, want.last_of_run,
                     want.buffer_overflowed, got.out_byte, got.last_of_run,
                     got.buffer_overflowed);
    endtask

    task automatic check_cut_byte(t_out_item got);
        t_out_item want;
        if (expected_cut_bytes.size() == 0) begin
            want = '0;
            report_mismatch("no result expected", want, got);
        end else begin
            want = expected_cut_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run ||
                got.buffer_overflowed !== want.buffer_overflowed)
                report_mismatch("field differs", want, got);
        end
    endtask

    int unsigned rx_stall;
    t_out_item   rx_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                rx_item.out_byte          = out_ch.out_byte;
                rx_item.last_of_run       = out_ch.last_of_run;
                rx_item.buffer_overflowed = out_ch.buffer_overflowed;
                check_cut_byte(rx_item);
                rx_stall = rx_idle_on ? $urandom_range(0, 4) : 0;
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            out_ch.ready <= (rx_stall == 0) && (hold_left == 0);
        end
    end

    // Drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------
    task automatic queue_byte(logic [7:0] b);
        text_token_t t;
        t.data_byte     = b;
        t.end_of_stream = 1'b0;
        pending_tokens.push_back(t);
        queued_tokens++;
    endtask

    // End of stream carries a random, ignored byte.
    task automatic queue_eos();
        text_token_t t;
        t.data_byte     = $urandom_range(0, 255);
        t.end_of_stream = 1'b1;
        pending_tokens.push_back(t);
        queued_tokens++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    // Write one register and mirror it into the predictor once the write is taken.
    task automatic write_register(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_FIELD_MODE:   sel_field_mode  = val[0];
            CFG_DELIMITER:    sel_delim       = val[7:0];
            CFG_SUPPRESS:     sel_suppress    = val[0];
            CFG_RANGE_COUNT:  sel_range_count = val[2:0];
            CFG_RANGE_WORD_0: sel_ranges[0]   = val;
            CFG_RANGE_WORD_1: sel_ranges[1]   = val;
            CFG_RANGE_WORD_2: sel_ranges[2]   = val;
            CFG_RANGE_WORD_3: sel_ranges[3]   = val;
            default: ;
        endcase
    endtask

    task automatic load_config(logic fm, logic [7:0] dl, logic sup, logic [2:0] cnt,
                               logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                               logic [31:0] w3);
        write_register(CFG_FIELD_MODE, {31'd0, fm});
        write_register(CFG_DELIMITER, {24'd0, dl});
        write_register(CFG_SUPPRESS, {31'd0, sup});
        write_register(CFG_RANGE_COUNT, {29'd0, cnt});
        write_register(CFG_RANGE_WORD_0, w0);
        write_register(CFG_RANGE_WORD_1, w1);
        write_register(CFG_RANGE_WORD_2, w2);
        write_register(CFG_RANGE_WORD_3, w3);
    endtask

    task automatic load_random_config();
        logic [7:0]  dl;
        logic [31:0] w[4];
        case ($urandom_range(0, 5))
            0: dl = TAB_BYTE;
            1: dl = COMMA_BYTE;
            2: dl = 8'h00;
            3: dl = 8'hFF;
            4: dl = NEWLINE_BYTE;
            default: dl = $urandom_range(0, 255);
        endcase
        // Mostly small bounds so ranges hit; now and then a full random word.
        foreach (w[i])
            w[i] = ($urandom_range(0, 7) == 0) ? $urandom()
                 : {16'($urandom_range(0, 6)), 16'($urandom_range(0, 5))};
        load_config($urandom_range(0, 1), dl, $urandom_range(0, 1), $urandom_range(0, 7),
                    w[0], w[1], w[2], w[3]);
    endtask

    // A well-formed line: fields of random content joined by the current delimiter.
    task automatic queue_random_line();
        int unsigned fields;
        int unsigned len;
        logic [7:0]  b;
        fields = $urandom_range(1, 5);
        for (int f = 0; f < fields; f++) begin
            if (f > 0)
                queue_byte(sel_delim);
            // Now and then a first field long enough to overflow the store.
            len = (f == 0 && $urandom_range(0, 7) == 0) ? $urandom_range(STORE_DEPTH - 3,
                  STORE_DEPTH + 5) : $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
                do b = $urandom_range(0, 255); while (b == NEWLINE_BYTE || b == sel_delim);
                queue_byte(b);
            end
        end
        case ($urandom_range(0, 9))
            8: queue_eos();
            9: ;
            default: queue_byte(NEWLINE_BYTE);
        endcase
    endtask

    // Unstructured bytes of any value, sometimes closed by an end of stream.
    task automatic queue_noise();
        int unsigned len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            queue_byte($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            queue_eos();
    endtask

    // Wait until every token is taken and every result is in, then let the block settle.
    task automatic wait_drained();
        while (accepted_tokens != queued_tokens || expected_cut_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------------------
    int unsigned phase_start;

    initial begin
        cfg_ch.valid        = 1'b0;
        cfg_ch.addr         = '0;
        cfg_ch.data         = '0;

        // Reset values of the predictor.
        sel_field_mode  = 1'b0;
        sel_delim       = TAB_BYTE;
        sel_suppress    = 1'b0;
        sel_range_count = 3'd0;
        foreach (sel_ranges[i])
            sel_ranges[i] = 32'd0;
        foreach (head_store[i])
            head_store[i] = 8'd0;
        clear_line();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: byte mode with no ranges passes only line ends.
        queue_text("ab\n");
        queue_eos();
        wait_drained();

        // Byte mode: range count above the slots, first position zero, last below
        // first, open-ended range, extreme byte values.
        tx_idle_on <= 1'b1;
        rx_idle_on <= 1'b1;
        load_config(1'b0, TAB_BYTE, 1'b0, 3'd7, {16'd2, 16'd0}, {16'd3, 16'd5},
                    {16'd0, 16'd6}, {16'd4, 16'd4});
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h80);
        queue_byte(8'h7F);
        queue_text("efg\n");
        queue_eos();
        wait_drained();

        // Field mode: fields one and three onward, an undelimited line passed whole,
        // an unterminated line flushed at end of stream.
        load_config(1'b1, COMMA_BYTE, 1'b0, 3'd2, {16'd1, 16'd1}, {16'd0, 16'd3},
                    32'd0, 32'd0);
        queue_text("ab,c,d,e\n");
        queue_text("xyz\n");
        queue_byte("q");
        queue_eos();
        wait_drained();

        // Delimiter equal to newline with suppression: every line is dropped.
        load_config(1'b1, NEWLINE_BYTE, 1'b1, 3'd1, {16'd0, 16'd2}, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_text("k\n");
        queue_byte("z");
        queue_eos();
        wait_drained();

        // Random phases; lines may be left open across register writes on purpose.
        for (int p = 0; p < 6; p++) begin
            tx_idle_on <= $urandom_range(0, 1);
            rx_idle_on <= $urandom_range(0, 1);
            if (p == 1) begin
                // Select everything and stall the result side so the block backs up.
                load_config(1'b1, COMMA_BYTE, 1'b0, 3'd1, {16'd0, 16'd1}, 32'd0, 32'd0,
                            32'd0);
                long_hold_req <= 1'b1;
            end else begin
                load_random_config();
            end
            phase_start = queued_tokens;
            while (queued_tokens - phase_start < 15) begin
                if ($urandom_range(0, 5) == 0)
                    queue_noise();
                else
                    queue_random_line();
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
